[design/nir_pkg.sv]
// ----------------------------------------------------------------------------
// nir_pkg
// shared types, codes and constants of the 4bpp image rotator
// ----------------------------------------------------------------------------
package nir_pkg;

	localparam int SIDE_W = 9;
	localparam int ROT_W = 3;
	localparam int CFG_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int ROW_W = 8;
	localparam int COL_W = 7;
	localparam int BYTE_W = 8;
	localparam int NIB_W = 4;
	localparam int STS_W = 2;

	localparam int DEF_MAX_SIDE = 256;
	localparam int DEF_STORE_BYTES = 32768;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT = 2'd2;

	localparam logic [SIDE_W-1:0] WIDTH_RST = 9'd256;
	localparam logic [SIDE_W-1:0] HEIGHT_RST = 9'd256;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [ROT_W-1:0] ROT_0 = 3'd0;
	localparam logic [ROT_W-1:0] ROT_90 = 3'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 3'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 3'd3;

	localparam logic [STS_W-1:0] ST_OK = 2'd0;
	localparam logic [STS_W-1:0] ST_BAD_ROT = 2'd1;
	localparam logic [STS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic               command;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   byte_column;
		logic [BYTE_W-1:0]  write_byte;
	} nir_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic [STS_W-1:0]   status;
	} nir_out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic eval;
		logic addr;
		logic mem_lo;
		logic mem_hi;
		logic finish;
	} nir_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic err;
		logic single;
	} nir_sts_t;

endpackage

[design/nir_ctrl.sv]
// ----------------------------------------------------------------------------
// nir_ctrl
// sequencer: evaluate, address, up to two memory accesses, result load
// ----------------------------------------------------------------------------
module nir_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	output logic              res_valid,
	input  logic              res_stall,
	output nir_pkg::nir_cmd_t cmd,
	input  nir_pkg::nir_sts_t sts
);
	import nir_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EVAL = 6'b000010,
		S_ADDR = 6'b000100,
		S_MLO  = 6'b001000,
		S_MHI  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   slot_free;

	assign slot_free = !res_valid_q || !res_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (src_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_ADDR;
			end
			S_ADDR: begin
				state_d = sts.err ? S_FIN : S_MLO;
			end
			S_MLO: begin
				// stores and unrotated reads need a single access
				state_d = sts.single ? S_FIN : S_MHI;
			end
			S_MHI: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign src_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	assign cmd.capture = (state_q == S_IDLE) && src_valid;
	assign cmd.eval    = (state_q == S_EVAL);
	assign cmd.addr    = (state_q == S_ADDR);
	assign cmd.mem_lo  = (state_q == S_MLO);
	assign cmd.mem_hi  = (state_q == S_MHI);
	assign cmd.finish  = (state_q == S_FIN) && slot_free;

endmodule

[design/nir_dp.sv]
// ----------------------------------------------------------------------------
// nir_dp
// datapath: config registers, coordinate mapping, source store, result build
// ----------------------------------------------------------------------------
module nir_dp #(
	parameter int MAX_SIDE = nir_pkg::DEF_MAX_SIDE,
	parameter int STORE_BYTES = nir_pkg::DEF_STORE_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [nir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nir_pkg::CFG_W-1:0]         cfg_data,
	input  nir_pkg::nir_in_t                  src_item,
	input  nir_pkg::nir_cmd_t                 cmd,
	output nir_pkg::nir_sts_t                 sts,
	output nir_pkg::nir_out_t                 res_item
);
	import nir_pkg::*;

	localparam int ROW_BYTES = (MAX_SIDE + 1) / 2;
	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int PW = SIDE_W + $clog2(ROW_BYTES + 1) + 1;
	localparam int AFW = (PW > AW + 1) ? PW : AW + 1;

	// configuration
	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	logic [ROT_W-1:0]  rot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			rot_q <= ROT_0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q <= cfg_data[SIDE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIDE_W-1:0];
				REG_ROT:    rot_q <= cfg_data[ROT_W-1:0];
				default:    ;
			endcase
		end
	end

	// transaction capture
	nir_in_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= src_item;
		end
	end

	// evaluation: sizes, status and source coordinates
	logic [SIDE_W-1:0] w;
	logic [SIDE_W-1:0] h;
	logic [SIDE_W-1:0] dw;
	logic [SIDE_W-1:0] dh;
	logic [SIDE_W-1:0] wb;
	logic [SIDE_W-1:0] dwb;
	logic [SIDE_W-1:0] nx;
	logic [SIDE_W-1:0] ry;
	logic [SIDE_W-1:0] col9;
	logic              quarter;
	logic              is_store;
	logic [STS_W-1:0]  status_d;
	logic [SIDE_W-1:0] xl_d;
	logic [SIDE_W-1:0] yl_d;
	logic [SIDE_W-1:0] xh_d;
	logic [SIDE_W-1:0] yh_d;

	assign w = (int'(width_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : width_q;
	assign h = (int'(height_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : height_q;
	assign quarter = (rot_q == ROT_90) || (rot_q == ROT_270);
	assign dw = quarter ? h : w;
	assign dh = quarter ? w : h;
	assign wb = SIDE_W'(({1'b0, w} + 10'd1) >> 1);
	assign dwb = SIDE_W'(({1'b0, dw} + 10'd1) >> 1);
	assign nx = {1'b0, item_q.byte_column, 1'b0};
	assign ry = {1'b0, item_q.row};
	assign col9 = {2'b00, item_q.byte_column};
	assign is_store = (item_q.command == CMD_STORE);

	always_comb begin
		if (is_store) begin
			status_d = (ry >= h || col9 >= wb) ? ST_RANGE : ST_OK;
		end else if (rot_q > ROT_270) begin
			status_d = ST_BAD_ROT;
		end else if (ry >= dh || col9 >= dwb) begin
			status_d = ST_RANGE;
		end else begin
			status_d = ST_OK;
		end
	end

	// the high pixel sits one step further along the rotated row
	always_comb begin
		xl_d = nx;
		yl_d = ry;
		xh_d = nx;
		yh_d = ry;
		if (!is_store) begin
			case (rot_q)
				ROT_90: begin
					xl_d = ry;
					yl_d = h - 9'd1 - nx;
					xh_d = ry;
					yh_d = h - 9'd2 - nx;
				end
				ROT_180: begin
					xl_d = w - 9'd1 - nx;
					yl_d = h - 9'd1 - ry;
					xh_d = w - 9'd2 - nx;
					yh_d = h - 9'd1 - ry;
				end
				ROT_270: begin
					xl_d = w - 9'd1 - ry;
					yl_d = nx;
					xh_d = w - 9'd1 - ry;
					yh_d = nx + 9'd1;
				end
				default: begin
					xl_d = nx;
					yl_d = ry;
					xh_d = nx;
					yh_d = ry;
				end
			endcase
		end
	end

	logic [STS_W-1:0]  status_q;
	logic [SIDE_W-1:0] xl_q;
	logic [SIDE_W-1:0] yl_q;
	logic [SIDE_W-1:0] xh_q;
	logic [SIDE_W-1:0] yh_q;
	logic              hi_ok_q;
	logic              single_q;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			status_q <= status_d;
			xl_q <= xl_d;
			yl_q <= yl_d;
			xh_q <= xh_d;
			yh_q <= yh_d;
			hi_ok_q <= ((nx + 9'd1) < dw);
			single_q <= is_store || (rot_q == ROT_0);
		end
	end

	assign sts.err = (status_q != ST_OK);
	assign sts.single = single_q;

	// byte addresses of both source pixels
	logic [AFW-1:0] addr_lo;
	logic [AFW-1:0] addr_hi;
	logic [AW-1:0]  addr_lo_q;
	logic [AW-1:0]  addr_hi_q;
	logic           lo_in_q;
	logic           hi_in_q;

	assign addr_lo = AFW'(yl_q) * AFW'(ROW_BYTES) + AFW'(xl_q[SIDE_W-1:1]);
	assign addr_hi = AFW'(yh_q) * AFW'(ROW_BYTES) + AFW'(xh_q[SIDE_W-1:1]);

	always_ff @(posedge clk) begin
		if (cmd.addr) begin
			addr_lo_q <= addr_lo[AW-1:0];
			addr_hi_q <= addr_hi[AW-1:0];
			lo_in_q <= (addr_lo < AFW'(STORE_BYTES));
			hi_in_q <= (addr_hi < AFW'(STORE_BYTES));
		end
	end

	// source store, single port, registered read
	logic [BYTE_W-1:0] mem [STORE_BYTES];
	logic [BYTE_W-1:0] rd_q;
	logic [BYTE_W-1:0] lo_byte_q;
	logic [AW-1:0]     mem_addr;
	logic              mem_we;
	logic              mem_re;

	assign mem_addr = cmd.mem_hi ? addr_hi_q : addr_lo_q;
	assign mem_we = cmd.mem_lo && is_store && lo_in_q;
	assign mem_re = (cmd.mem_lo && !is_store && lo_in_q) || (cmd.mem_hi && hi_in_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= item_q.write_byte;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
		if (cmd.mem_hi) begin
			lo_byte_q <= rd_q;
		end
	end

	// result assembly
	logic [BYTE_W-1:0] lo_byte;
	logic [BYTE_W-1:0] hi_byte;
	logic [NIB_W-1:0]  lo_nib;
	logic [NIB_W-1:0]  hi_nib;
	nir_out_t          res_d;
	nir_out_t          res_q;

	assign lo_byte = lo_in_q ? (single_q ? rd_q : lo_byte_q) : '0;
	assign hi_byte = hi_in_q ? rd_q : '0;
	assign lo_nib = xl_q[0] ? lo_byte[BYTE_W-1:NIB_W] : lo_byte[NIB_W-1:0];
	assign hi_nib = !hi_ok_q ? '0 : (xh_q[0] ? hi_byte[BYTE_W-1:NIB_W] : hi_byte[NIB_W-1:0]);

	always_comb begin
		res_d.status = status_q;
		if (status_q != ST_OK || is_store) begin
			res_d.out_byte = '0;
		end else if (single_q) begin
			res_d.out_byte = lo_byte;
		end else begin
			res_d.out_byte = {hi_nib, lo_nib};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign res_item = res_q;

endmodule

[design/nibble_image_rotator.sv]
// after acceptance the sequencer evaluates and computes addresses, then loads the result
// directly on an error status; a store or an unrotated read first makes one access to
// the single-port source store, a rotated read two (two source nibbles from two bytes)
// one transaction in flight; the next is accepted once the result is loaded
// reset (arst_n low) returns the sequencer to idle, drops any pending result and sets
// width 256, height 256, rotation 0; the source store is not cleared
// ----------------------------------------------------------------------------
// nibble_image_rotator
// 4bpp image store with 0/90/180/270 degree rotated byte readout
// ----------------------------------------------------------------------------
module nibble_image_rotator #(
	parameter int MAX_SIDE = nir_pkg::DEF_MAX_SIDE,
	parameter int STORE_BYTES = nir_pkg::DEF_STORE_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  nir_pkg::nir_in_t              src_item,
	output logic                          res_valid,
	input  logic                          res_stall,
	output nir_pkg::nir_out_t             res_item,
	input  logic                          cfg_we,
	input  logic [nir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nir_pkg::CFG_W-1:0]     cfg_data
);
	import nir_pkg::*;

	nir_cmd_t cmd;
	nir_sts_t sts;

	nir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	nir_dp #(
		.MAX_SIDE    (MAX_SIDE),
		.STORE_BYTES (STORE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_item  (src_item),
		.cmd       (cmd),
		.sts       (sts),
		.res_item  (res_item)
	);

endmodule

[design/nir_chk.sv]
// ----------------------------------------------------------------------------
// nir_chk
// port-level checks of the rotator, bound to the top level
// ----------------------------------------------------------------------------
module nir_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          src_valid,
	input logic                          src_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input nir_pkg::nir_out_t             res_item
);
	import nir_pkg::*;

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("input accepted while a transaction is in progress");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed or dropped");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status != ST_OK |-> res_item.out_byte == '0)
		else $error("non-zero byte with error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.status == ST_OK || res_item.status == ST_BAD_ROT
			|| res_item.status == ST_RANGE)
		else $error("undefined status code");

	// a result only follows work in progress
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(src_stall))
		else $error("result appeared without a transaction");

endmodule

bind nibble_image_rotator nir_chk u_nir_chk (.*);

[verif/nir_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nir_checker
// follows the input, result and register ports of the 4bpp image rotator,
// keeps its own copy of the source image and settings, works out the answer
// to every accepted transaction and compares it with what comes out
// ----------------------------------------------------------------------------
module nir_checker import nir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	input  logic                 src_stall,
	input  nir_in_t              src_item,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  nir_out_t             res_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   outstanding,
	output int                   mismatches
);

	localparam int ROW_BYTES = (DEF_MAX_SIDE + 1) / 2;

	logic [BYTE_W-1:0] source_bytes [DEF_STORE_BYTES];
	logic [SIDE_W-1:0] width_reg = WIDTH_RST;
	logic [SIDE_W-1:0] height_reg = HEIGHT_RST;
	logic [ROT_W-1:0]  rot_reg = ROT_0;
	nir_out_t          answer_q [$];
	int                answers_waiting = 0;
	int                mismatch_total = 0;

	assign outstanding = answers_waiting;
	assign mismatches = mismatch_total;

	function automatic int side_of(logic [SIDE_W-1:0] v);
		return (v > DEF_MAX_SIDE) ? DEF_MAX_SIDE : int'(v);
	endfunction

	function automatic logic [NIB_W-1:0] source_nibble(int x, int y);
		logic [BYTE_W-1:0] b;
		b = source_bytes[y * ROW_BYTES + x / 2];
		return (x % 2 == 1) ? b[7:4] : b[3:0];
	endfunction

	// nx, ny index the rotated image; w, h are the source sizes
	function automatic logic [NIB_W-1:0] rotated_nibble(logic [ROT_W-1:0] rot, int nx, int ny,
			int w, int h);
		if (rot == ROT_90)
			return source_nibble(ny, h - 1 - nx);
		if (rot == ROT_180)
			return source_nibble(w - 1 - nx, h - 1 - ny);
		return source_nibble(w - 1 - ny, nx);
	endfunction

	task automatic predict_rotator(input nir_in_t t, output nir_out_t r);
		int w, h, dw, dh, nx;
		logic [NIB_W-1:0] lo, hi;
		w = side_of(width_reg);
		h = side_of(height_reg);
		r = '0;
		if (t.command == CMD_STORE) begin
			if (t.row >= h || t.byte_column >= (w + 1) / 2)
				r.status = ST_RANGE;
			else
				source_bytes[t.row * ROW_BYTES + t.byte_column] = t.write_byte;
		end else if (rot_reg > ROT_270) begin
			r.status = ST_BAD_ROT;
		end else begin
			if (rot_reg == ROT_90 || rot_reg == ROT_270) begin
				dw = h;
				dh = w;
			end else begin
				dw = w;
				dh = h;
			end
			if (t.row >= dh || t.byte_column >= (dw + 1) / 2) begin
				r.status = ST_RANGE;
			end else if (rot_reg == ROT_0) begin
				r.out_byte = source_bytes[t.row * ROW_BYTES + t.byte_column];
			end else begin
				nx = 2 * t.byte_column;
				lo = rotated_nibble(rot_reg, nx, t.row, w, h);
				// padding nibble past an odd rotated width
				hi = (nx + 1 < dw) ? rotated_nibble(rot_reg, nx + 1, t.row, w, h) : '0;
				r.out_byte = {hi, lo};
			end
		end
	endtask

	task automatic report_mismatch(string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatch_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		nir_out_t want, fresh;
		if (!arst_n) begin
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			rot_reg = ROT_0;
			answer_q.delete();
			answers_waiting <= 0;
		end else begin
			// results first, so a result never pairs with a transaction of the same edge
			if (res_valid && !res_stall) begin
				if (answer_q.size() == 0) begin
					report_mismatch($sformatf("result %h/%h with nothing outstanding",
						res_item.out_byte, res_item.status));
				end else begin
					want = answer_q.pop_front();
					if (res_item.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte got %h expected %h",
							res_item.out_byte, want.out_byte));
					if (res_item.status !== want.status)
						report_mismatch($sformatf("status got %h expected %h",
							res_item.status, want.status));
				end
			end
			if (src_valid && !src_stall) begin
				predict_rotator(src_item, fresh);
				answer_q.push_back(fresh);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: width_reg = cfg_data[SIDE_W-1:0];
					REG_HEIGHT: height_reg = cfg_data[SIDE_W-1:0];
					REG_ROT: rot_reg = cfg_data[ROT_W-1:0];
					default: ;
				endcase
			end
			answers_waiting <= answer_q.size();
		end
	end

endmodule

[verif/tb_nibble_image_rotator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nibble_image_rotator
// drives stores, rotated reads and register writes into the 4bpp rotator with
// random gaps and stalls; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_nibble_image_rotator;
	import nir_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [ROT_W-1:0] ROT_BAD_LO = 3'd4;
	localparam logic [ROT_W-1:0] ROT_BAD_MID = 3'd6;
	localparam logic [ROT_W-1:0] ROT_BAD_HI = 3'd7;
	localparam int ROW_BYTES = (DEF_MAX_SIDE + 1) / 2;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 250;
	localparam int NUM_PHASES = 18;
	localparam int TABLE_PHASES = 12;
	localparam int PHASE_ITEMS = 26;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 src_valid = 1'b0;
	logic                 src_stall;
	nir_in_t              src_item = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	nir_out_t             res_item;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int outstanding;
	int mismatches;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_serial = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;

	// sizes as the block sees them, for shaping stimulus only
	int               cur_w = DEF_MAX_SIDE;
	int               cur_h = DEF_MAX_SIDE;
	logic [ROT_W-1:0] cur_rot = ROT_0;
	bit               stored_once [DEF_STORE_BYTES];

	int               phase_w [TABLE_PHASES] = '{8, 5, 256, 1, 7, 511, 2, 0, 9, 6, 255, 3};
	int               phase_h [TABLE_PHASES] = '{8, 7, 1, 256, 3, 2, 511, 6, 0, 5, 3, 255};
	logic [ROT_W-1:0] phase_r [TABLE_PHASES] = '{ROT_90, ROT_180, ROT_90, ROT_270, ROT_270,
		ROT_180, ROT_90, ROT_90, ROT_0, ROT_BAD_MID, ROT_0, ROT_180};
	int               idle_mode [4] = '{0, 66, 0, 23};
	int               stall_mode [4] = '{0, 0, 66, 23};

	nibble_image_rotator uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	nir_checker rot_check (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_serial != hold_seen) begin
			hold_seen <= hold_serial;
			hold_left <= LONG_HOLD;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_transaction(input logic cmd, input int row, input int col,
			input logic [BYTE_W-1:0] data);
		nir_in_t t;
		t.command = cmd;
		t.row = row[ROW_W-1:0];
		t.byte_column = col[COL_W-1:0];
		t.write_byte = data;
		while ($urandom_range(99) < idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= t;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		if (cmd == CMD_STORE && row < cur_h && col < (cur_w + 1) / 2)
			stored_once[row * ROW_BYTES + col] = 1'b1;
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_config(input int w_raw, input int h_raw,
			input logic [ROT_W-1:0] rot_raw, input bit spare);
		logic [CFG_W-1:0] rot_word;
		wait_drained();
		// junk in the unused upper bits of the rotation write
		rot_word = CFG_W'($urandom_range(511));
		rot_word[ROT_W-1:0] = rot_raw;
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w_raw[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h_raw[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_ROT;
		cfg_data <= rot_word;
		@(posedge clk);
		if (spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= CFG_W'($urandom_range(511));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_w = (w_raw > DEF_MAX_SIDE) ? DEF_MAX_SIDE : w_raw;
		cur_h = (h_raw > DEF_MAX_SIDE) ? DEF_MAX_SIDE : h_raw;
		cur_rot = rot_raw;
	endtask

	// every byte of the current image gets written before any rotated read
	task automatic fill_region();
		for (int y = 0; y < cur_h; y++)
			for (int c = 0; c < (cur_w + 1) / 2; c++)
				if (!stored_once[y * ROW_BYTES + c])
					send_transaction(CMD_STORE, y, c, BYTE_W'($urandom_range(255)));
	endtask

	task automatic random_transaction();
		int pick, dw, dh;
		pick = $urandom_range(99);
		if (cur_rot == ROT_90 || cur_rot == ROT_270) begin
			dw = cur_h;
			dh = cur_w;
		end else begin
			dw = cur_w;
			dh = cur_h;
		end
		if (pick < 45 && dw > 0 && dh > 0 && cur_rot <= ROT_270)
			send_transaction(CMD_READ, $urandom_range(dh - 1), $urandom_range((dw + 1) / 2 - 1),
				BYTE_W'($urandom_range(255)));
		else if (pick < 72 && cur_w > 0 && cur_h > 0)
			send_transaction(CMD_STORE, $urandom_range(cur_h - 1),
				$urandom_range((cur_w + 1) / 2 - 1), BYTE_W'($urandom_range(255)));
		else
			send_transaction(1'($urandom_range(1)), $urandom_range(255), $urandom_range(127),
				BYTE_W'($urandom_range(255)));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners of the full-size image, unrotated
		send_transaction(CMD_STORE, 0, 0, 8'hF0);
		send_transaction(CMD_STORE, 255, 127, 8'h0F);
		send_transaction(CMD_STORE, 0, 127, 8'hFF);
		send_transaction(CMD_STORE, 255, 0, 8'hA5);
		send_transaction(CMD_READ, 0, 0, 8'h00);
		send_transaction(CMD_READ, 255, 127, 8'hFF);
		send_transaction(CMD_READ, 0, 127, 8'h00);
		send_transaction(CMD_READ, 255, 0, 8'h00);

		// bad rotation: stores unaffected, reads flag it ahead of the range check
		program_config(DEF_MAX_SIDE, DEF_MAX_SIDE, ROT_BAD_HI, 1'b0);
		send_transaction(CMD_STORE, 10, 10, 8'h3C);
		send_transaction(CMD_READ, 0, 0, 8'h00);
		send_transaction(CMD_READ, 255, 127, 8'h00);
		program_config(0, 0, ROT_BAD_LO, 1'b0);
		send_transaction(CMD_STORE, 0, 0, 8'h12);
		send_transaction(CMD_READ, 0, 0, 8'h00);
		program_config(0, 0, ROT_0, 1'b0);
		send_transaction(CMD_READ, 0, 0, 8'h00);

		// odd sizes in both directions, so every rotation has a padding nibble
		program_config(3, 5, ROT_90, 1'b0);
		fill_region();
		send_transaction(CMD_READ, 0, 2, 8'h00);
		send_transaction(CMD_READ, 2, 0, 8'h00);
		send_transaction(CMD_READ, 3, 0, 8'h00);
		program_config(3, 5, ROT_180, 1'b0);
		send_transaction(CMD_READ, 4, 1, 8'h00);
		send_transaction(CMD_READ, 0, 2, 8'h00);
		program_config(3, 5, ROT_270, 1'b0);
		send_transaction(CMD_READ, 0, 2, 8'h00);
		send_transaction(CMD_READ, 2, 2, 8'h00);
		program_config(3, 5, ROT_0, 1'b0);
		send_transaction(CMD_READ, 0, 1, 8'h00);
		send_transaction(CMD_STORE, 0, 2, 8'h77);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			idle_pct = idle_mode[ph % 4];
			stall_pct <= stall_mode[ph % 4];
			if (ph < TABLE_PHASES)
				program_config(phase_w[ph], phase_h[ph], phase_r[ph], ph == 7);
			else
				program_config($urandom_range(16, 1), $urandom_range(16, 1),
					ROT_W'(($urandom_range(9) == 0) ? $urandom_range(ROT_BAD_HI, ROT_BAD_LO)
						: $urandom_range(ROT_270, ROT_0)), 1'b0);
			fill_region();
			// long receiver hold-off while the sender keeps offering
			if (ph % 8 == 0)
				hold_serial <= hold_serial + 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 5 && i == PHASE_ITEMS / 2)
					wait_drained();
				random_transaction();
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
